### src/pba_pkg.sv
// Package for the PCI BAR window allocator.
// It holds the outcome codes, the register indexes, the BAR field masks and the shared structs.
// It depends on nothing else.
package pba_pkg;

    // Outcome codes carried by each result item
    localparam logic [2:0] OUT_RESTARTED  = 3'd0;
    localparam logic [2:0] OUT_IO_SKIPPED = 3'd1;
    localparam logic [2:0] OUT_UPPER_SKIP = 3'd2;
    localparam logic [2:0] OUT_UNIMPL     = 3'd3;
    localparam logic [2:0] OUT_ASSIGNED   = 3'd4;
    localparam logic [2:0] OUT_NO_SPACE   = 3'd5;
    localparam logic [2:0] OUT_STOPPED    = 3'd6;

    // Command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_PROBE   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_WINDOW_BASE = 1'b0;
    localparam logic CFG_WINDOW_END  = 1'b1;

    // Number of BAR slots in one function
    localparam logic [2:0] BAR_SLOTS = 3'd6;

    // BAR word fields
    localparam logic [31:0] ADDR_MASK = 32'hffff_fff0;
    localparam int          IO_BIT    = 0;
    localparam logic [1:0]  TYPE_64   = 2'b10;

    // Top of the 32-bit window, in the widened address arithmetic
    localparam logic [33:0] LIMIT32 = 34'h1_0000_0000;

    // Allocator state
    typedef struct packed {
        logic [32:0] next_free;
        logic        skip_upper;
        logic        device_stopped;
    } pba_state_t;

    // One probe item
    typedef struct packed {
        logic        cmd;
        logic [2:0]  slot_index;
        logic [31:0] bar_original;
        logic [31:0] bar_readback;
    } pba_item_t;

    // One result item
    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] bar_value;
        logic        clear_upper;
        logic [31:0] bar_size;
        logic [32:0] next_address;
    } pba_result_t;

    // Window configuration
    typedef struct packed {
        logic [31:0] window_base;
        logic [32:0] window_end;
    } pba_cfg_t;

endpackage

### src/pba_cfg_regs.sv
// Configuration registers of the PCI BAR window allocator.
// It decodes the plain write port into the window base and end registers.
// It depends on pba_pkg.
module pba_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [32:0]       cfg_wdata,
    output pba_pkg::pba_cfg_t cfg
);
    import pba_pkg::*;

    logic [31:0] window_base_reg;
    logic [31:0] window_base_next;
    logic [32:0] window_end_reg;
    logic [32:0] window_end_next;

    // Register decode: each index writes its own register.
    always_comb
    begin
        window_base_next = window_base_reg;
        window_end_next  = window_end_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_BASE: window_base_next = cfg_wdata[31:0];
                CFG_WINDOW_END:  window_end_next  = cfg_wdata;
                default:         window_end_next  = window_end_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= '0;
            window_end_reg  <= '0;
        end
        else
        begin
            window_base_reg <= window_base_next;
            window_end_reg  <= window_end_next;
        end
    end

    assign cfg.window_base = window_base_reg;
    assign cfg.window_end  = window_end_reg;

endmodule

### src/pba_step.sv
// Single-pass step logic of the PCI BAR window allocator.
// It sizes one BAR, aligns the next free address and decides the outcome and the next state.
// It depends on pba_pkg.
module pba_step (
    input  pba_pkg::pba_item_t   item,
    input  pba_pkg::pba_state_t  state,
    input  pba_pkg::pba_cfg_t    cfg,
    output pba_pkg::pba_result_t result,
    output pba_pkg::pba_state_t  state_next
);
    import pba_pkg::*;

    logic        wide;
    logic        new_function;
    logic [31:0] mask;
    logic [31:0] size;
    logic [33:0] size_m1;
    logic [33:0] base;
    logic [33:0] end_addr;
    logic        overflow;

    // Size decoding and alignment: the size is the lowest set address bit of the readback.
    always_comb
    begin
        wide         = (item.bar_original[2:1] == TYPE_64);
        new_function = (item.slot_index == 3'd0);
        mask         = item.bar_readback & ADDR_MASK;
        size         = mask & (~mask + 32'd1);
        size_m1      = {2'b00, size} - 34'd1;
        base         = ({1'b0, state.next_free} + size_m1) & ~size_m1;
        end_addr     = base + {2'b00, size};
        overflow     = (end_addr > {1'b0, cfg.window_end}) || (end_addr > LIMIT32);
    end

    // Outcome selection and state update.
    always_comb
    begin
        state_next          = state;
        result.outcome      = OUT_STOPPED;
        result.bar_value    = item.bar_original;
        result.clear_upper  = 1'b0;
        result.bar_size     = '0;

        if (item.cmd == CMD_RESTART)
        begin
            state_next.next_free      = {1'b0, cfg.window_base};
            state_next.skip_upper     = 1'b0;
            state_next.device_stopped = 1'b0;
            result.outcome            = OUT_RESTARTED;
            result.bar_value          = '0;
        end
        else if (item.slot_index < BAR_SLOTS)
        begin
            // A new function starts with both flags clear.
            if (new_function)
            begin
                state_next.skip_upper     = 1'b0;
                state_next.device_stopped = 1'b0;
            end

            if (state_next.device_stopped)
            begin
                result.outcome = OUT_STOPPED;
            end
            else if (state_next.skip_upper)
            begin
                state_next.skip_upper = 1'b0;
                result.outcome        = OUT_UPPER_SKIP;
            end
            else if (item.bar_original[IO_BIT])
            begin
                result.outcome = OUT_IO_SKIPPED;
            end
            else if (mask == 32'd0)
            begin
                state_next.skip_upper = wide;
                result.outcome        = OUT_UNIMPL;
            end
            else if (overflow)
            begin
                state_next.device_stopped = 1'b1;
                result.outcome            = OUT_NO_SPACE;
                result.bar_size           = size;
            end
            else
            begin
                state_next.next_free  = end_addr[32:0];
                state_next.skip_upper = wide;
                result.outcome        = OUT_ASSIGNED;
                result.bar_value      = base[31:0] | {28'd0, item.bar_original[3:0]};
                result.clear_upper    = wide;
                result.bar_size       = size;
            end
        end

        result.next_address = state_next.next_free;
    end

endmodule

### src/pci_bar_window_allocator.sv
// Top level of the PCI BAR window allocator.
// It holds the input register, the allocator state and the result register around the step logic.
// It depends on pba_pkg, pba_cfg_regs and pba_step.
//
//   Channel   Handshake                Fields
//   input     in_valid / in_stall      cmd, slot_index, bar_original, bar_readback
//   result    out_valid / out_stall    outcome, bar_value, clear_upper, bar_size, next_address
//   config    cfg_we                   cfg_index, cfg_wdata
//
// An item passes from acceptance into the input register, and then through the step logic into
// the result register. One item is accepted every cycle while the result side is not stalled,
// with a single update of the allocator state per item. Reset clears the state, the window
// registers and both valid flags. A stalled result holds the item behind it in the input
// register, and in_stall rises only when both registers are full.
module pci_bar_window_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [32:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [2:0]  slot_index,
    input  logic [31:0] bar_original,
    input  logic [31:0] bar_readback,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  outcome,
    output logic [31:0] bar_value,
    output logic        clear_upper,
    output logic [31:0] bar_size,
    output logic [32:0] next_address
);
    import pba_pkg::*;

    pba_cfg_t    cfg;
    pba_item_t   item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    pba_state_t  state_reg;
    pba_state_t  state_next;
    pba_result_t step_result;
    pba_result_t result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        fire;
    logic        accept;

    pba_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pba_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .result     (step_result),
        .state_next (state_next)
    );

    // Handshake control: the result register frees when empty or being taken.
    always_comb
    begin
        advance         = !out_valid_reg || !out_stall;
        fire            = item_valid_reg && advance;
        in_stall        = item_valid_reg && !advance;
        accept          = in_valid && !in_stall;
        item_valid_next = accept ? 1'b1 : (fire ? 1'b0 : item_valid_reg);
        out_valid_next  = fire ? 1'b1 : (advance ? 1'b0 : out_valid_reg);
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd          <= cmd;
            item_reg.slot_index   <= slot_index;
            item_reg.bar_original <= bar_original;
            item_reg.bar_readback <= bar_readback;
        end
        if (fire)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = result_reg.outcome;
    assign bar_value    = result_reg.bar_value;
    assign clear_upper  = result_reg.clear_upper;
    assign bar_size     = result_reg.bar_size;
    assign next_address = result_reg.next_address;

`ifndef NO_ASSERTIONS
    // The input side only stalls when the result register is full and held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could move");

    // An assigned BAR always has a power-of-two size.
    a_assigned_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OUT_ASSIGNED) |-> $onehot(bar_size))
        else $error("assigned BAR without a power-of-two size");

    // The upper word is only cleared for an assigned BAR.
    a_clear_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_upper) |-> (outcome == OUT_ASSIGNED))
        else $error("upper word cleared without an assignment");

    // A restart reports the window base as the next free address.
    a_restart_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OUT_RESTARTED) |-> (next_address == {1'b0, cfg.window_base}))
        else $error("restart did not reload the window base");
`endif

endmodule
